// File: design/data_run_list_decoder_macros.svh
// Assertion helpers for the run list decoder
`ifndef DATA_RUN_LIST_DECODER_MACROS_SVH
`define DATA_RUN_LIST_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define DRLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset
`define DRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/drld_pkg.sv
package drld_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_LEN  = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_CORRUPT = 2'd2,
        KIND_OVER    = 2'd3
    } t_kind;

    // Register byte addresses (8-byte spacing)
    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_START_VCN = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_MAX_RUNS  = 4'h8;

    // Largest byte count a header nibble may carry
    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;
    localparam logic [15:0] MAX_RUNS_RST = 16'hFFFF;

    // One queued result; then_done appends a list-complete word after it
    typedef struct packed {
        t_kind              kind;
        logic        [63:0] vcn;
        logic signed [63:0] lcn;
        logic        [63:0] len;
        logic               sparse;
        logic        [15:0] count;
        logic               then_done;
    } t_res;

endpackage

// File: design/data_run_list_decoder.sv
// Channel | Dir | Handshake         | Word
// s_*     | in  | s_tvalid/s_tready | stream byte, first-byte flag, last-byte flag
// m_*     | out | m_tvalid/m_tready | one run entry or list status
// APB     | in  | psel/penable      | start_vcn at 0x0, max_runs at 0x8
//
// One stream byte is decoded in the cycle it is accepted: the byte insert,
// sign extension and the 64-bit cluster adds sit between the input port and
// the state registers, so a byte is taken every cycle while the queue has room.
// Results wait in a two-entry queue; s_tready drops only when both are full.
// A run that ends the stream yields a second word (list complete) from the
// same queue entry.
// Reset (synchronous, active low) empties the queue and idles the decoder.
`include "data_run_list_decoder_macros.svh"

module data_run_list_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drld_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] first_byte
    input  logic                         s_tlast,   // last_byte
    // Output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [207:0]                 m_tdata,   // [63:0] run_vcn, [127:64] run_lcn,
                                                    // [191:128] run_length,
                                                    // [207:192] run_count
    output logic [2:0]                   m_tuser,   // [1:0] kind, [2] sparse
    output logic                         m_tlast    // last
);
    import drld_pkg::*;

    // Configuration
    logic [63:0] r_start_vcn;
    logic [15:0] r_max_runs;

    // Decoder state
    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [3:0]  r_off_left, n_off_left;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_len_acc, n_len_acc;
    logic [63:0] r_del_acc, n_del_acc;
    logic        r_sparse, n_sparse;
    logic [63:0] r_cur_lcn, n_cur_lcn;
    logic [63:0] r_cur_vcn, n_cur_vcn;
    logic [15:0] r_runs, n_runs;

    // Result queue
    t_res        r_q [2];
    logic        r_wp, r_rp, r_sub;
    logic [1:0]  r_cnt;

    logic        w_acc, w_push, w_pop, w_done;
    t_res        w_res, w_head;
    t_phase      w_ph;
    logic [63:0] w_vcn0, w_lcn0, w_ins, w_del, w_lcn_sum;
    logic [15:0] w_cnt0;
    logic [3:0]  w_lb, w_ob, w_nb;

    // Sign-extend a delta of nb bytes (nb of 8 needs nothing)
    function automatic logic [63:0] sext_delta(input logic [63:0] d, input logic [3:0] nb);
        logic [63:0] r;
        begin
            r = d;
            unique case (nb)
                4'd1:    r = {{56{d[7]}},  d[7:0]};
                4'd2:    r = {{48{d[15]}}, d[15:0]};
                4'd3:    r = {{40{d[23]}}, d[23:0]};
                4'd4:    r = {{32{d[31]}}, d[31:0]};
                4'd5:    r = {{24{d[39]}}, d[39:0]};
                4'd6:    r = {{16{d[47]}}, d[47:0]};
                4'd7:    r = {{8{d[55]}},  d[55:0]};
                default: r = d;
            endcase
            return r;
        end
    endfunction

    // APB: always ready, decode on address bit 3
    assign pready = 1'b1;
    assign prdata = paddr[3] ? {48'b0, r_max_runs} : r_start_vcn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vcn <= '0;
            r_max_runs  <= MAX_RUNS_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == ADDR_MAX_RUNS[3]) begin
                r_max_runs <= pwdata[15:0];
            end else begin
                r_start_vcn <= pwdata;
            end
        end
    end

    // Handshakes
    assign s_tready = (r_cnt != 2'd2);
    assign w_acc    = s_tvalid && s_tready;

    // Base values: a first byte restarts the stream
    assign w_ph   = s_tuser ? PH_HEAD : r_phase;
    assign w_vcn0 = s_tuser ? r_start_vcn : r_cur_vcn;
    assign w_lcn0 = s_tuser ? 64'd0 : r_cur_lcn;
    assign w_cnt0 = s_tuser ? 16'd0 : r_runs;
    assign w_lb   = s_tdata[3:0];
    assign w_ob   = s_tdata[7:4];
    assign w_ins  = {56'b0, s_tdata} << {r_pos[2:0], 3'b000};
    assign w_nb   = r_pos + 4'd1;

    // Decode one byte
    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_off_left = r_off_left;
        n_pos      = r_pos;
        n_len_acc  = r_len_acc;
        n_del_acc  = r_del_acc;
        n_sparse   = r_sparse;
        n_cur_lcn  = r_cur_lcn;
        n_cur_vcn  = r_cur_vcn;
        n_runs     = r_runs;
        w_push     = 1'b0;
        w_done     = 1'b0;
        w_del      = r_del_acc | w_ins;
        w_lcn_sum  = '0;
        w_res      = '0;
        w_res.count = w_cnt0;
        if (w_acc) begin
            if (s_tuser) begin
                n_cur_vcn = r_start_vcn;
                n_cur_lcn = '0;
                n_runs    = '0;
                n_phase   = PH_HEAD;
            end
            unique case (w_ph)
                PH_IDLE: begin
                end
                PH_HEAD: begin
                    priority if (s_tdata == 8'd0) begin
                        w_push      = 1'b1;
                        w_res.kind  = KIND_DONE;
                        n_phase     = PH_IDLE;
                    end else if (w_cnt0 >= r_max_runs) begin
                        w_push      = 1'b1;
                        w_res.kind  = KIND_OVER;
                        n_phase     = PH_IDLE;
                    end else if (w_lb > MAX_FIELD_BYTES || w_ob > MAX_FIELD_BYTES) begin
                        w_push      = 1'b1;
                        w_res.kind  = KIND_CORRUPT;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_len_left = w_lb;
                        n_off_left = w_ob;
                        n_sparse   = (w_ob == 4'd0);
                        n_len_acc  = '0;
                        n_del_acc  = '0;
                        n_pos      = '0;
                        n_phase    = (w_lb != 4'd0) ? PH_LEN : PH_OFF;
                        if (s_tlast) begin
                            w_push     = 1'b1;
                            w_res.kind = KIND_CORRUPT;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                PH_LEN: begin
                    n_len_acc  = r_len_acc | w_ins;
                    n_pos      = w_nb;
                    n_len_left = r_len_left - 4'd1;
                    if (n_len_left == 4'd0) begin
                        n_pos = '0;
                        if (r_off_left == 4'd0) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_OFF;
                        end
                    end
                end
                PH_OFF: begin
                    n_del_acc  = w_del;
                    n_pos      = w_nb;
                    n_off_left = r_off_left - 4'd1;
                    if (n_off_left == 4'd0) begin
                        n_del_acc = sext_delta(w_del, w_nb);
                        n_pos     = '0;
                        w_done    = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Close the run, or flag a run cut short by the last byte
            if (w_done) begin
                w_lcn_sum = w_lcn0 + n_del_acc;
                if (!r_sparse) begin
                    n_cur_lcn = w_lcn_sum;
                end
                n_cur_vcn       = w_vcn0 + n_len_acc;
                n_runs          = w_cnt0 + 16'd1;
                w_push          = 1'b1;
                w_res.kind      = KIND_RUN;
                w_res.vcn       = w_vcn0;
                w_res.lcn       = r_sparse ? '1 : w_lcn_sum;
                w_res.len       = n_len_acc;
                w_res.sparse    = r_sparse;
                w_res.count     = n_runs;
                w_res.then_done = s_tlast;
                n_phase         = s_tlast ? PH_IDLE : PH_HEAD;
            end else if (s_tlast && (w_ph == PH_LEN || w_ph == PH_OFF)) begin
                w_push     = 1'b1;
                w_res.kind = KIND_CORRUPT;
                n_phase    = PH_IDLE;
            end
        end
    end

    // Update decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_len_left <= '0;
            r_off_left <= '0;
            r_pos      <= '0;
            r_len_acc  <= '0;
            r_del_acc  <= '0;
            r_sparse   <= 1'b0;
            r_cur_lcn  <= '0;
            r_cur_vcn  <= '0;
            r_runs     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_pos      <= n_pos;
            r_len_acc  <= n_len_acc;
            r_del_acc  <= n_del_acc;
            r_sparse   <= n_sparse;
            r_cur_lcn  <= n_cur_lcn;
            r_cur_vcn  <= n_cur_vcn;
            r_runs     <= n_runs;
        end
    end

    // Output queue: pop after the trailing list-complete word, if any
    assign w_head = r_q[r_rp];
    assign w_pop  = m_tvalid && m_tready && (r_sub || !w_head.then_done);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (m_tvalid && m_tready) begin
                r_sub <= !r_sub && w_head.then_done;
            end
        end
    end

    // Drive the output word
    assign m_tvalid = (r_cnt != 2'd0);

    always_comb begin
        if (r_sub) begin
            m_tuser = {1'b0, KIND_DONE};
            m_tdata = {w_head.count, 192'b0};
            m_tlast = 1'b1;
        end else begin
            m_tuser = {w_head.sparse, w_head.kind};
            m_tdata = {w_head.count, w_head.len, w_head.lcn, w_head.vcn};
            m_tlast = !w_head.then_done;
        end
    end

    // Checks
    `DRLD_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= 2'd2, "result queue count out of range")
    `DRLD_ASSERT_NOW(a_sub_head, r_sub, (r_cnt != 2'd0) && w_head.then_done, "trailing word without a run entry")
    `DRLD_ASSERT_NOW(a_idle_quiet, w_acc && !s_tuser && r_phase == PH_IDLE, !w_push, "idle byte produced a result")
    `DRLD_ASSERT_NEXT(a_done_idle, w_acc && w_push && (w_res.kind != KIND_RUN), r_phase == PH_IDLE, "status word left decoder active")

endmodule
